>>> rtl/ort_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the outstanding request tracker.
package ort_pkg;

	localparam int ENTRIES   = 64;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int KEY_W     = 48;
	localparam int OWNER_W   = 32;
	localparam int SLOT_W    = 6;
	localparam int LIMIT_W   = 7;
	localparam int COUNT_W   = 7;

	localparam logic [15:0]        RESERVED_MID = 16'hFFFF;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 7'd64;

	typedef enum logic [2:0] {
		OP_ADD      = 3'd0,
		OP_REMOVE   = 3'd1,
		OP_CANCEL   = 3'd2,
		OP_SET_EXEC = 3'd3,
		OP_QUERY    = 3'd4
	} op_e;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_RESERVED  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_LIMIT     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_MISMATCH  = 3'd5
	} status_e;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_SLOT_RD,
		S_FINISH
	} state_e;

	typedef struct packed {
		logic [2:0]        op;
		logic [31:0]       process_id;
		logic [15:0]       message_id;
		logic [15:0]       user_id;
		logic [15:0]       tree_id;
		logic [SLOT_W-1:0] slot_in;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [SLOT_W-1:0]  slot_out;
		logic               is_cancelled;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [OWNER_W-1:0] owner;
		logic               executing;
		logic               cancelled;
	} entry_t;

	typedef struct packed {
		logic             clear;
		logic             issue;
		logic [IDX_W-1:0] issue_idx;
		logic             issue_free;
	} scan_ctl_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		entry_t           hit_entry;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
	} scan_res_t;

endpackage

>>> rtl/ort_entry_ram.sv
`timescale 1ns / 1ps
// Entry memory: key, owner and marks of each slot, one write and one registered read port.
module ort_entry_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ort_pkg::IDX_W-1:0] waddr,
	input  ort_pkg::entry_t           wdata,
	input  logic [ort_pkg::IDX_W-1:0] raddr,
	output ort_pkg::entry_t           rdata
);
	import ort_pkg::*;

	entry_t mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/ort_scan.sv
`timescale 1ns / 1ps
// Key search over the entry memory: compare stage, first hit and lowest free slot.
module ort_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ort_pkg::scan_ctl_t        ctl,
	input  logic [ort_pkg::KEY_W-1:0] key,
	input  ort_pkg::entry_t           rd_data,
	output ort_pkg::scan_res_t        res
);
	import ort_pkg::*;

	logic             cmp_vld_s1;
	logic             cmp_trk_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             hit_q;
	logic             free_found_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] free_idx_q;
	entry_t           hit_entry_q;
	logic             match;
	logic             take_free;

	assign match     = cmp_vld_s1 && cmp_trk_s1 && (rd_data.key == key) && !hit_q;
	assign take_free = ctl.issue && ctl.issue_free && !free_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1   <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= ctl.issue;
			if (ctl.clear) begin
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (match) begin
					hit_q <= 1'b1;
				end
				if (take_free) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= ctl.issue_idx;
		cmp_trk_s1 <= !ctl.issue_free;
		if (match) begin
			hit_idx_q   <= cmp_idx_s1;
			hit_entry_q <= rd_data;
		end
		if (take_free) begin
			free_idx_q <= ctl.issue_idx;
		end
	end

	always_comb begin
		res.hit        = hit_q;
		res.hit_idx    = hit_idx_q;
		res.hit_entry  = hit_entry_q;
		res.free_found = free_found_q;
		res.free_idx   = free_idx_q;
	end

endmodule

>>> rtl/outstanding_request_tracker_core.sv
`timescale 1ns / 1ps
// Top level of the outstanding request tracker: sequencer, tracked marks, count and result.
//
// Use: an item on in_valid/in_ready carries one operation (add, remove, cancel by key,
// set executing, query cancelled); exactly one result item leaves on out_valid/out_ready.
// cfg_valid/cfg_ready writes request_limit; cfg_ready is always high. Write it only
// while the block is idle.
// Steps per item: add and cancel by key read every slot of the entry memory once through
// its single read port in the scan state, then pass the last state and the finish state.
// Set executing and query read one slot of the memory, then finish; remove, reserved
// ids and unused op codes go straight to the finish step. out_valid rises with in_ready.
// in_ready is high only in the idle state. A finished result sits in the output
// register; the block takes the next item while it waits, and stalls in its final
// step only when a second result is ready before the first has been taken.
// Reset: no entry tracked, count zero, request_limit 64, output empty. The key and
// owner memory is not cleared; a per-slot tracked mark in flip-flops guards it, so
// there is no clearing pass.
module outstanding_request_tracker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ort_pkg::req_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ort_pkg::rsp_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ort_pkg::LIMIT_W-1:0]   cfg_data
);
	import ort_pkg::*;

	state_e             state_q;
	state_e             state_nxt;
	req_t               item_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic [LIMIT_W-1:0] limit_q;
	logic [ENTRIES-1:0] tracked_q;
	logic               out_valid_q;
	rsp_t               out_q;

	scan_ctl_t          scan_ctl;
	scan_res_t          scan_res;
	entry_t             rd_data;
	logic [IDX_W-1:0]   rd_addr;
	logic               accept;
	logic               fin_fire;
	logic               in_reserved;

	logic [KEY_W-1:0]   key;
	logic [OWNER_W-1:0] owner;
	logic               reserved;
	logic [IDX_W-1:0]   slot_idx;
	logic               slot_tracked;

	logic [2:0]         status;
	logic [SLOT_W-1:0]  slot_out;
	logic               cancelled;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	entry_t             wdata;
	logic               trk_set;
	logic               trk_clr;

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign accept      = in_valid && in_ready;
	assign in_reserved = (in_data.message_id == RESERVED_MID);

	assign key          = {item_q.process_id, item_q.message_id};
	assign owner        = {item_q.user_id, item_q.tree_id};
	assign reserved     = (item_q.message_id == RESERVED_MID);
	assign slot_idx     = IDX_W'(item_q.slot_in);
	assign slot_tracked = (32'(item_q.slot_in) < 32'(ENTRIES)) && tracked_q[slot_idx];

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (op_e'(in_data.op))
						OP_ADD, OP_CANCEL: state_nxt = in_reserved ? S_FINISH : S_SCAN;
						OP_SET_EXEC, OP_QUERY: state_nxt = S_SLOT_RD;
						default: state_nxt = S_FINISH;
					endcase
				end
			end
			S_SCAN: begin
				if (idx_q == IDX_W'(ENTRIES - 1)) begin
					state_nxt = S_LAST;
				end
			end
			S_LAST: state_nxt = S_FINISH;
			S_SLOT_RD: state_nxt = S_FINISH;
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready            = (state_q == S_IDLE);
		fin_fire            = (state_q == S_FINISH) && (!out_valid_q || out_ready);
		scan_ctl.clear      = (state_q == S_IDLE);
		scan_ctl.issue      = (state_q == S_SCAN);
		scan_ctl.issue_idx  = idx_q;
		scan_ctl.issue_free = !tracked_q[idx_q];
		rd_addr             = (state_q == S_SCAN) ? idx_q : slot_idx;
	end

	always_comb begin
		status    = ST_OK;
		slot_out  = '0;
		cancelled = 1'b0;
		we        = 1'b0;
		waddr     = slot_idx;
		wdata     = rd_data;
		trk_set   = 1'b0;
		trk_clr   = 1'b0;
		count_nxt = count_q;
		case (op_e'(item_q.op))
			OP_ADD: begin
				if (reserved) begin
					status = ST_RESERVED;
				end else if (scan_res.hit) begin
					status = ST_DUPLICATE;
				end else if ((32'(count_q) >= 32'(limit_q)) || !scan_res.free_found) begin
					status = ST_LIMIT;
				end else begin
					we              = 1'b1;
					waddr           = scan_res.free_idx;
					wdata.key       = key;
					wdata.owner     = owner;
					wdata.executing = 1'b0;
					wdata.cancelled = 1'b0;
					trk_set         = 1'b1;
					count_nxt       = count_q + CNT_W'(1);
					slot_out        = SLOT_W'(scan_res.free_idx);
				end
			end
			OP_REMOVE: begin
				if (slot_tracked) begin
					trk_clr   = 1'b1;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_CANCEL: begin
				if (reserved || !scan_res.hit) begin
					status = ST_NOT_FOUND;
				end else if (scan_res.hit_entry.owner != owner) begin
					status = ST_MISMATCH;
				end else begin
					we              = 1'b1;
					waddr           = scan_res.hit_idx;
					wdata           = scan_res.hit_entry;
					wdata.cancelled = 1'b1;
				end
			end
			OP_SET_EXEC: begin
				if (slot_tracked) begin
					we              = 1'b1;
					wdata.executing = 1'b1;
				end
			end
			OP_QUERY: begin
				cancelled = slot_tracked && rd_data.cancelled;
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	ort_entry_ram u_ram (
		.clk   (clk),
		.we    (we && fin_fire),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	ort_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.key     (key),
		.rd_data (rd_data),
		.res     (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			limit_q     <= LIMIT_RESET;
			tracked_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (fin_fire) begin
				count_q <= count_nxt;
				if (trk_set) begin
					tracked_q[scan_res.free_idx] <= 1'b1;
				end
				if (trk_clr) begin
					tracked_q[slot_idx] <= 1'b0;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (state_q == S_SCAN) begin
			idx_q <= idx_q + IDX_W'(1);
		end else begin
			idx_q <= '0;
		end
		if (fin_fire) begin
			out_q.status       <= status;
			out_q.slot_out     <= slot_out;
			out_q.is_cancelled <= cancelled;
			out_q.entry_count  <= COUNT_W'(count_nxt);
		end
	end

endmodule

>>> bench/tb_outstanding_request_tracker_core.sv
`timescale 1ns / 1ps
// Testbench for the outstanding request tracker core: directed table, then random phases.
module tb_outstanding_request_tracker_core;
	import ort_pkg::*;

	localparam int          CYCLE_LIMIT     = 1_000_000;
	localparam int          SETTLE_CYCLES   = ENTRIES + 16;
	localparam int          HOLD_OFF_CYCLES = 400;
	localparam int          NOISE_PCT       = 12;
	localparam int          PRINT_CAP       = 100;
	localparam logic [2:0]  OP_SPARE_FIRST  = 3'd5;
	localparam logic [2:0]  OP_SPARE_LAST   = 3'd7;
	localparam logic [6:0]  LIMIT_NONE      = 7'd0;
	localparam logic [6:0]  LIMIT_ONE       = 7'd1;
	localparam logic [6:0]  LIMIT_SOME      = 7'd20;
	localparam logic [6:0]  LIMIT_TOP       = 7'd127;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t want;
	} table_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	logic [KEY_W-1:0]   stored_key   [ENTRIES];
	logic [OWNER_W-1:0] stored_owner [ENTRIES];
	bit                 live_mark    [ENTRIES];
	bit                 exec_mark    [ENTRIES];
	bit                 cancel_mark  [ENTRIES];
	int                 live_total;
	logic [LIMIT_W-1:0] limit_model;

	rsp_t       due_responses [$];
	rsp_t       due_head;
	table_row_t directed_rows [$];
	int         fail_count     = 0;
	int         cycle_count    = 0;
	int         send_idle_pct  = 36;
	int         recv_idle_pct  = 58;
	bit         hold_off_req   = 1'b0;

	outstanding_request_tracker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic rsp_t apply_to_table(req_t r);
		rsp_t               rsp;
		logic [KEY_W-1:0]   key;
		logic [OWNER_W-1:0] owner;
		int                 hit;
		int                 free_slot;
		bit                 slot_live;
		rsp       = '0;
		key       = {r.process_id, r.message_id};
		owner     = {r.user_id, r.tree_id};
		hit       = -1;
		free_slot = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (live_mark[i] && stored_key[i] == key)
				hit = i;
			if (!live_mark[i])
				free_slot = i;
		end
		slot_live  = live_mark[r.slot_in];
		rsp.status = ST_OK;
		case (r.op)
			OP_ADD: begin
				if (r.message_id == RESERVED_MID)
					rsp.status = ST_RESERVED;
				else if (hit >= 0)
					rsp.status = ST_DUPLICATE;
				else if (live_total >= limit_model || free_slot < 0)
					rsp.status = ST_LIMIT;
				else begin
					stored_key[free_slot]   = key;
					stored_owner[free_slot] = owner;
					live_mark[free_slot]    = 1'b1;
					exec_mark[free_slot]    = 1'b0;
					cancel_mark[free_slot]  = 1'b0;
					live_total++;
					rsp.slot_out = free_slot[SLOT_W-1:0];
				end
			end
			OP_REMOVE: begin
				if (slot_live) begin
					live_mark[r.slot_in]   = 1'b0;
					exec_mark[r.slot_in]   = 1'b0;
					cancel_mark[r.slot_in] = 1'b0;
					live_total--;
				end
			end
			OP_CANCEL: begin
				if (r.message_id == RESERVED_MID || hit < 0)
					rsp.status = ST_NOT_FOUND;
				else if (stored_owner[hit] != owner)
					rsp.status = ST_MISMATCH;
				else
					cancel_mark[hit] = 1'b1;
			end
			OP_SET_EXEC: begin
				if (slot_live)
					exec_mark[r.slot_in] = 1'b1;
			end
			OP_QUERY: rsp.is_cancelled = slot_live && cancel_mark[r.slot_in];
			default: ;
		endcase
		rsp.entry_count = live_total[COUNT_W-1:0];
		return rsp;
	endfunction

	function automatic int pick_live_slot();
		int live [$];
		for (int i = 0; i < ENTRIES; i++)
			if (live_mark[i])
				live.push_back(i);
		if (live.size() == 0)
			return -1;
		return live[$urandom_range(live.size() - 1)];
	endfunction

	function automatic req_t make_request(int add_pct);
		req_t r;
		int   live;
		int   k;
		r.op         = OP_QUERY;
		r.process_id = $urandom;
		r.message_id = 16'($urandom_range(65535));
		r.user_id    = 16'($urandom_range(65535));
		r.tree_id    = 16'($urandom_range(65535));
		r.slot_in    = SLOT_W'($urandom_range(63));
		live         = pick_live_slot();
		if ($urandom_range(99) < NOISE_PCT) begin
			r.op = 3'($urandom_range(7));
			if ($urandom_range(7) == 0)
				r.message_id = RESERVED_MID;
			return r;
		end
		if ($urandom_range(99) < add_pct) begin
			r.op = OP_ADD;
			k    = $urandom_range(9);
			if (k == 0)
				r.message_id = RESERVED_MID;
			else if (k == 1 && live >= 0)
				{r.process_id, r.message_id} = stored_key[live];
			return r;
		end
		k = $urandom_range(99);
		if (k < 25)
			r.op = OP_REMOVE;
		else if (k < 55)
			r.op = OP_CANCEL;
		else if (k < 75)
			r.op = OP_SET_EXEC;
		if (live >= 0 && $urandom_range(9) != 0) begin
			r.slot_in                    = SLOT_W'(live);
			{r.process_id, r.message_id} = stored_key[live];
			{r.user_id, r.tree_id}       = stored_owner[live];
			k = $urandom_range(9);
			if (k == 8)
				r.user_id ^= 16'($urandom_range(65535, 1));
			else if (k == 9)
				r.tree_id ^= 16'($urandom_range(65535, 1));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < PRINT_CAP)
			$display("%0t ns: %s got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_responses.size() == 0) begin
				report_mismatch("unexpected result, status", int'(out_data.status), -1);
			end else begin
				due_head = due_responses.pop_front();
				if (out_data.status !== due_head.status)
					report_mismatch("status", int'(out_data.status), int'(due_head.status));
				if (out_data.slot_out !== due_head.slot_out)
					report_mismatch("slot_out", int'(out_data.slot_out),
						int'(due_head.slot_out));
				if (out_data.is_cancelled !== due_head.is_cancelled)
					report_mismatch("is_cancelled", int'(out_data.is_cancelled),
						int'(due_head.is_cancelled));
				if (out_data.entry_count !== due_head.entry_count)
					report_mismatch("entry_count", int'(out_data.entry_count),
						int'(due_head.entry_count));
			end
		end
	end

	initial begin
		int hold_left;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready = 1'b0;
				for (hold_left = HOLD_OFF_CYCLES; hold_left > 0; hold_left--)
					@(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Entered and left at a falling edge; valid stays high between back-to-back items.
	task automatic send_request(input req_t r, input bit typed, input rsp_t want);
		rsp_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = r;
		do @(posedge clk); while (!in_ready);
		predicted = apply_to_table(r);
		due_responses.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic settle();
		while (due_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		limit_model = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic add_row(input logic [2:0] op, input logic [31:0] pid, input logic [15:0] mid,
			input logic [15:0] uid, input logic [15:0] tid, input logic [SLOT_W-1:0] slot,
			input bit typed, input logic [2:0] st, input logic [SLOT_W-1:0] slot_out,
			input bit cancelled, input logic [COUNT_W-1:0] count);
		table_row_t row;
		row.req.op         = op;
		row.req.process_id = pid;
		row.req.message_id = mid;
		row.req.user_id    = uid;
		row.req.tree_id    = tid;
		row.req.slot_in    = slot;
		row.typed          = typed;
		row.want           = '{st, slot_out, cancelled, count};
		directed_rows.push_back(row);
	endtask

	task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int send_pct,
			input int recv_pct, input int add_pct, input int items, input bit hold);
		settle();
		write_limit(limit);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (hold)
			hold_off_req = 1'b1;
		repeat (items) send_request(make_request(add_pct), 1'b0, '0);
		in_valid = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			live_mark[i]   = 1'b0;
			exec_mark[i]   = 1'b0;
			cancel_mark[i] = 1'b0;
		end
		live_total  = 0;
		limit_model = LIMIT_RESET;

		add_row(OP_QUERY, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0, 1, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_REMOVE, 32'h0, 16'h0, 16'h0, 16'h0, 6'd63, 1, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_SET_EXEC, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0, 1, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_ADD, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0, 1, ST_OK, 6'd0, 0, 7'd1);
		add_row(OP_ADD, 32'hFFFF_FFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 6'd63,
			1, ST_OK, 6'd1, 0, 7'd2);
		add_row(OP_ADD, 32'h1, RESERVED_MID, 16'h0, 16'h0, 6'd0, 1, ST_RESERVED, 6'd0, 0, 7'd2);
		add_row(OP_ADD, 32'h0, 16'h0, 16'h1, 16'h1, 6'd0, 1, ST_DUPLICATE, 6'd0, 0, 7'd2);
		add_row(OP_CANCEL, 32'hFFFF_FFFF, 16'hFFFE, 16'hFFFF, 16'h0, 6'd0,
			1, ST_MISMATCH, 6'd0, 0, 7'd2);
		add_row(OP_CANCEL, 32'hFFFF_FFFF, 16'hFFFE, 16'h0, 16'hFFFF, 6'd0,
			1, ST_MISMATCH, 6'd0, 0, 7'd2);
		add_row(OP_CANCEL, 32'hFFFF_FFFF, RESERVED_MID, 16'hFFFF, 16'hFFFF, 6'd0,
			1, ST_NOT_FOUND, 6'd0, 0, 7'd2);
		add_row(OP_CANCEL, 32'h1234_5678, 16'h0, 16'h0, 16'h0, 6'd0,
			1, ST_NOT_FOUND, 6'd0, 0, 7'd2);
		add_row(OP_CANCEL, 32'hFFFF_FFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 6'd0,
			0, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_QUERY, 32'h0, 16'h0, 16'h0, 16'h0, 6'd1, 0, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_SET_EXEC, 32'h0, 16'h0, 16'h0, 16'h0, 6'd1, 0, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_QUERY, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0, 0, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_SPARE_FIRST, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63,
			1, ST_OK, 6'd0, 0, 7'd2);
		add_row(OP_SPARE_LAST, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd1,
			1, ST_OK, 6'd0, 0, 7'd2);
		add_row(OP_REMOVE, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0, 0, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_ADD, 32'h0, 16'h1, 16'h0, 16'h0, 6'd0, 0, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_QUERY, 32'h0, 16'h0, 16'h0, 16'h0, 6'd1, 0, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_REMOVE, 32'h0, 16'h0, 16'h0, 16'h0, 6'd1, 0, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_QUERY, 32'h0, 16'h0, 16'h0, 16'h0, 6'd1, 0, ST_OK, 6'd0, 0, 7'd0);
		add_row(OP_CANCEL, 32'h0, 16'h1, 16'h0, 16'h0, 6'd0, 0, ST_OK, 6'd0, 0, 7'd0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		in_valid = 1'b0;

		run_phase(LIMIT_TOP, 36, 58, 70, 260, 1'b0);
		run_phase(LIMIT_NONE, 36, 58, 40, 250, 1'b0);
		run_phase(LIMIT_ONE, 58, 36, 15, 250, 1'b0);
		run_phase(LIMIT_RESET, 58, 36, 55, 260, 1'b1);
		run_phase(LIMIT_SOME, 0, 0, 50, 260, 1'b0);
		run_phase(LIMIT_TOP, 0, 0, 45, 250, 1'b0);

		settle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
